// File: hw/rtl/sckey_pkg.sv
// ----------------------------------------------------------------------------
// sckey_pkg
// Shared types, constants and the US layout character table for the
// scan code key event tracker.
// ----------------------------------------------------------------------------
package sckey_pkg;

   localparam int unsigned KEY_SLOTS   = 96;
   localparam int unsigned CODE_LIMIT  = 'h60;
   localparam int unsigned SCAN_W      = 8;
   localparam int unsigned CODE_W      = 7;
   localparam int unsigned CHAR_W      = 7;
   localparam int unsigned FIFO_DEPTH  = 4;
   localparam int unsigned FIFO_PTR_W  = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [1:0] {
      EV_PRESS   = 2'd0,
      EV_REPEAT  = 2'd1,
      EV_RELEASE = 2'd2
   } event_kind_type;

   typedef struct packed {
      event_kind_type           kind;
      logic [CODE_W-1:0]        code;
      logic [CHAR_W-1:0]        ascii;
      logic                     last;
   } rsp_item_type;

   function automatic logic [CHAR_W-1:0] us_char(input logic [CODE_W-1:0] code);
      logic [CHAR_W-1:0] ch;
      case (code)
         7'd1: begin ch = 7'h1B; end
         7'd2: begin ch = 7'h31; end
         7'd3: begin ch = 7'h32; end
         7'd4: begin ch = 7'h33; end
         7'd5: begin ch = 7'h34; end
         7'd6: begin ch = 7'h35; end
         7'd7: begin ch = 7'h36; end
         7'd8: begin ch = 7'h37; end
         7'd9: begin ch = 7'h38; end
         7'd10: begin ch = 7'h39; end
         7'd11: begin ch = 7'h30; end
         7'd12: begin ch = 7'h2D; end
         7'd13: begin ch = 7'h3D; end
         7'd14: begin ch = 7'h08; end
         7'd15: begin ch = 7'h09; end
         7'd16: begin ch = 7'h71; end
         7'd17: begin ch = 7'h77; end
         7'd18: begin ch = 7'h65; end
         7'd19: begin ch = 7'h72; end
         7'd20: begin ch = 7'h74; end
         7'd21: begin ch = 7'h79; end
         7'd22: begin ch = 7'h75; end
         7'd23: begin ch = 7'h69; end
         7'd24: begin ch = 7'h6F; end
         7'd25: begin ch = 7'h70; end
         7'd26: begin ch = 7'h5B; end
         7'd27: begin ch = 7'h5D; end
         7'd28: begin ch = 7'h0A; end
         7'd30: begin ch = 7'h61; end
         7'd31: begin ch = 7'h73; end
         7'd32: begin ch = 7'h64; end
         7'd33: begin ch = 7'h66; end
         7'd34: begin ch = 7'h67; end
         7'd35: begin ch = 7'h68; end
         7'd36: begin ch = 7'h6A; end
         7'd37: begin ch = 7'h6B; end
         7'd38: begin ch = 7'h6C; end
         7'd39: begin ch = 7'h3B; end
         7'd40: begin ch = 7'h27; end
         7'd41: begin ch = 7'h60; end
         7'd43: begin ch = 7'h5C; end
         7'd44: begin ch = 7'h7A; end
         7'd45: begin ch = 7'h78; end
         7'd46: begin ch = 7'h63; end
         7'd47: begin ch = 7'h76; end
         7'd48: begin ch = 7'h62; end
         7'd49: begin ch = 7'h6E; end
         7'd50: begin ch = 7'h6D; end
         7'd51: begin ch = 7'h2C; end
         7'd52: begin ch = 7'h2E; end
         7'd53: begin ch = 7'h2F; end
         7'd55: begin ch = 7'h2A; end
         7'd57: begin ch = 7'h20; end
         7'd74: begin ch = 7'h2D; end
         7'd78: begin ch = 7'h2B; end
         default: begin ch = 7'h00; end
      endcase
      return ch;
   endfunction

endpackage

// File: hw/rtl/scan_code_key_event_tracker_top.sv
// ----------------------------------------------------------------------------
// scan_code_key_event_tracker_top
// Turns raw keyboard bytes into press, repeat and release words.
//
// The req_ channel takes one word per keyboard read: the data-ready flag and
// the raw byte. Each accepted word yields up to two rsp_ words: a release of
// the previously seen key when the key changes, then a press or repeat word
// for the current key when its code is nonzero. rsp_last_event marks the
// final word caused by one input word; an input that causes nothing yields
// no word at all.
// Results are written into the queue and appear from its registered head.
// One input word can be taken every cycle while req_ready is high; a word
// with two results needs two output handshakes. req_ready is set by a
// four-entry result queue, which takes new input while it holds at most two
// results, so input and output handshakes are fully decoupled.
// A key only ever holds press or repeat while it is the most recent key, so
// the phase of every other key is idle or release and needs no table.
// Reset clears the queue and forgets the previous key. When the receiver
// stalls, results wait in the queue and req_ready drops once the queue holds
// more than two results.
// ----------------------------------------------------------------------------
module scan_code_key_event_tracker_top
   import sckey_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_data_ready,
   input  logic [SCAN_W-1:0] req_scan_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_event_kind,
   output logic [CODE_W-1:0] rsp_key_index,
   output logic [CHAR_W-1:0] rsp_ascii_char,
   output logic              rsp_last_event
);

   localparam logic [FIFO_CNT_W-1:0] READY_LIMIT = FIFO_CNT_W'(FIFO_DEPTH - 2);

   rsp_item_type            entries_ff [FIFO_DEPTH];
   rsp_item_type            entries_in [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic [CODE_W-1:0]       prev_code_ff, prev_code_in;
   logic                    prev_valid_ff, prev_valid_in;

   logic [SCAN_W-1:0]       raw_code;
   logic [CODE_W-1:0]       code;
   logic                    push, pop, rel, emit_key;
   logic [1:0]              push_n;
   rsp_item_type            rel_item, key_item, head;

   assign req_ready = (count_ff <= READY_LIMIT);
   assign rsp_valid = (count_ff != '0);
   assign push      = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      raw_code = req_data_ready ? req_scan_byte : '0;
      if (raw_code >= SCAN_W'(CODE_LIMIT) || 32'(raw_code) >= KEY_SLOTS) begin
         code = '0;
      end else begin
         code = raw_code[CODE_W-1:0];
      end
      emit_key = (code != '0);
      rel      = prev_valid_ff && (prev_code_ff != code);
      push_n   = {1'b0, rel} + {1'b0, emit_key};

      rel_item.kind  = EV_RELEASE;
      rel_item.code  = prev_code_ff;
      rel_item.ascii = us_char(prev_code_ff);
      rel_item.last  = !emit_key;

      key_item.kind  = (prev_valid_ff && !rel) ? EV_REPEAT : EV_PRESS;
      key_item.code  = code;
      key_item.ascii = us_char(code);
      key_item.last  = 1'b1;

      entries_in    = entries_ff;
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      prev_code_in  = prev_code_ff;
      prev_valid_in = prev_valid_ff;

      if (push) begin
         if (rel) begin
            entries_in[wr_ptr_ff] = rel_item;
         end
         if (emit_key) begin
            entries_in[wr_ptr_ff + FIFO_PTR_W'(rel)] = key_item;
         end
         wr_ptr_in     = wr_ptr_ff + FIFO_PTR_W'(push_n);
         prev_code_in  = code;
         prev_valid_in = 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + (push ? FIFO_CNT_W'(push_n) : '0) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
         prev_code_ff  <= '0;
         prev_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
         prev_code_ff  <= prev_code_in;
         prev_valid_ff <= prev_valid_in;
      end
   end

   assign head           = entries_ff[rd_ptr_ff];
   assign rsp_event_kind = head.kind;
   assign rsp_key_index  = head.code;
   assign rsp_ascii_char = head.ascii;
   assign rsp_last_event = head.last;

   // The queue never holds more results than it has entries.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("result queue overflow");

   // A release that is not the last word is followed by its key word at once.
   a_release_pair: assert property (@(posedge clock) disable iff (reset)
      (pop && head.kind == EV_RELEASE && !head.last) |=> rsp_valid)
      else $error("key word missing after release");

   // Once a key has been seen it is never forgotten until reset.
   a_prev_sticky: assert property (@(posedge clock) disable iff (reset)
      prev_valid_ff |=> prev_valid_ff)
      else $error("previous key lost");

endmodule

// File: dv/key_event_checker.sv
// ----------------------------------------------------------------------------
// key_event_checker
// Watches both channels of the scan code key event tracker. It keeps its own
// per-key phase table and the last key seen, derives the release, press and
// repeat words that each accepted keyboard word must cause, and compares every
// result word with the oldest one still awaited.
// ----------------------------------------------------------------------------
module key_event_checker
   import sckey_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              req_data_ready,
   input  logic [SCAN_W-1:0] req_scan_byte,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [1:0]        rsp_event_kind,
   input  logic [CODE_W-1:0] rsp_key_index,
   input  logic [CHAR_W-1:0] rsp_ascii_char,
   input  logic              rsp_last_event,
   output int                mismatch_count,
   output int                expected_pending
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {
      KEY_IDLE = 2'd0,
      KEY_DOWN = 2'd1,
      KEY_HELD = 2'd2,
      KEY_UP   = 2'd3
   } key_state_type;

   logic [CHAR_W-1:0] layout_char [KEY_SLOTS] = '{
      0, 27, 49, 50, 51, 52, 53, 54, 55, 56, 57, 48, 45, 61, 8, 9,
      113, 119, 101, 114, 116, 121, 117, 105, 111, 112, 91, 93, 10, 0, 97, 115,
      100, 102, 103, 104, 106, 107, 108, 59, 39, 96, 0, 92, 122, 120, 99, 118,
      98, 110, 109, 44, 46, 47, 0, 42, 0, 32, 0, 0, 0, 0, 0, 0,
      0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 45, 0, 0, 0, 43, 0,
      0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0
   };

   key_state_type     key_state [KEY_SLOTS];
   logic [CODE_W-1:0] last_code;
   logic              last_code_seen;
   rsp_item_type      expected_events [$];
   int                mismatch_total;

   initial begin
      mismatch_count   = 0;
      expected_pending = 0;
      mismatch_total   = 0;
   end

   task automatic flag_mismatch(input string what);
      mismatch_total++;
      $display("%0t ns key event mismatch: %s", $realtime, what);
   endtask

   task automatic predict_key_events(input logic data_ready,
                                     input logic [SCAN_W-1:0] scan_byte);
      logic [CODE_W-1:0] code;
      logic              has_key;
      rsp_item_type      ev;
      code = '0;
      if (data_ready && scan_byte < CODE_LIMIT) begin
         code = scan_byte[CODE_W-1:0];
      end
      case (key_state[code])
         KEY_IDLE, KEY_UP: begin
            key_state[code] = KEY_DOWN;
         end
         KEY_DOWN: begin
            key_state[code] = KEY_HELD;
         end
         default: begin
         end
      endcase
      has_key = (code != '0);
      if (last_code_seen && last_code != code) begin
         key_state[last_code] = KEY_UP;
         ev.kind  = EV_RELEASE;
         ev.code  = last_code;
         ev.ascii = layout_char[last_code];
         ev.last  = !has_key;
         expected_events.push_back(ev);
      end
      last_code      = code;
      last_code_seen = 1'b1;
      if (has_key) begin
         if (key_state[code] == KEY_HELD) begin
            ev.kind = EV_REPEAT;
         end else if (key_state[code] == KEY_UP) begin
            ev.kind = EV_RELEASE;
         end else begin
            ev.kind = EV_PRESS;
         end
         ev.code  = code;
         ev.ascii = layout_char[code];
         ev.last  = 1'b1;
         expected_events.push_back(ev);
      end
   endtask

   task automatic compare_key_event();
      rsp_item_type ev;
      if (expected_events.size() == 0) begin
         flag_mismatch($sformatf("unexpected word kind %0d key %0d",
                                 rsp_event_kind, rsp_key_index));
      end else begin
         ev = expected_events.pop_front();
         if (rsp_event_kind !== ev.kind) begin
            flag_mismatch($sformatf("event_kind %0d, wanted %0d (key %0d)",
                                    rsp_event_kind, ev.kind, ev.code));
         end
         if (rsp_key_index !== ev.code) begin
            flag_mismatch($sformatf("key_index %0d, wanted %0d",
                                    rsp_key_index, ev.code));
         end
         if (rsp_ascii_char !== ev.ascii) begin
            flag_mismatch($sformatf("ascii_char %0d, wanted %0d (key %0d)",
                                    rsp_ascii_char, ev.ascii, ev.code));
         end
         if (rsp_last_event !== ev.last) begin
            flag_mismatch($sformatf("last_event %0b, wanted %0b (key %0d)",
                                    rsp_last_event, ev.last, ev.code));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < KEY_SLOTS; k++) begin
            key_state[k] = KEY_IDLE;
         end
         last_code      = '0;
         last_code_seen = 1'b0;
         expected_events.delete();
      end else begin
         if (req_valid && req_ready) begin
            predict_key_events(req_data_ready, req_scan_byte);
         end
         if (rsp_valid && rsp_ready) begin
            compare_key_event();
         end
      end
      expected_pending <= expected_events.size();
      mismatch_count   <= mismatch_total;
   end

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top of the scan code key event tracker testbench. It drives a directed run
// of keyboard words covering held keys, key changes, empty reads and codes
// out of range, then random key sequences in three idling phases, including
// one long receiver hold-off that fills the result queue. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb
   import sckey_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RUN_LIMIT   = 200000;
   localparam int PHASE_WORDS = 284;
   localparam int HOLD_CYCLES = 200;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic              req_data_ready;
   logic [SCAN_W-1:0] req_scan_byte;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [1:0]        rsp_event_kind;
   logic [CODE_W-1:0] rsp_key_index;
   logic [CHAR_W-1:0] rsp_ascii_char;
   logic              rsp_last_event;
   int                mismatch_count;
   int                expected_pending;

   int unsigned       src_idle_pct;
   int unsigned       sink_idle_pct;
   int                load_phase;
   int                cycle_count;
   logic [SCAN_W-1:0] held_byte;

   scan_code_key_event_tracker_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_ready (req_data_ready),
      .req_scan_byte  (req_scan_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_kind (rsp_event_kind),
      .rsp_key_index  (rsp_key_index),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last_event (rsp_last_event)
   );

   key_event_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_ready   (req_data_ready),
      .req_scan_byte    (req_scan_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_key_index    (rsp_key_index),
      .rsp_ascii_char   (rsp_ascii_char),
      .rsp_last_event   (rsp_last_event),
      .mismatch_count   (mismatch_count),
      .expected_pending (expected_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // The receiver holds off once for a long stretch at the start of the phase
   // without idling, while the sender keeps offering words.
   initial begin : result_sink
      int  stall_left;
      bit  hold_taken;
      stall_left = 0;
      hold_taken = 1'b0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (load_phase == 2 && !hold_taken) begin
            hold_taken = 1'b1;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= sink_idle_pct);
         end
      end
   end

   // Entered and left at a falling edge; the word is held until accepted.
   task automatic send_word(input logic data_ready, input logic [SCAN_W-1:0] scan_byte);
      while ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_data_ready <= data_ready;
      req_scan_byte  <= scan_byte;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   task automatic send_random_word();
      int unsigned       roll;
      logic              data_ready;
      logic [SCAN_W-1:0] scan_byte;
      roll       = $urandom_range(99);
      data_ready = 1'b1;
      if (roll < 35) begin
         scan_byte = held_byte;
      end else if (roll < 70) begin
         held_byte = SCAN_W'($urandom_range(1, KEY_SLOTS - 1));
         scan_byte = held_byte;
      end else if (roll < 80) begin
         data_ready = 1'b0;
         scan_byte  = SCAN_W'($urandom);
      end else if (roll < 90) begin
         scan_byte = SCAN_W'($urandom_range(CODE_LIMIT, 255));
      end else begin
         data_ready = 1'($urandom);
         scan_byte  = SCAN_W'($urandom);
      end
      send_word(data_ready, scan_byte);
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data_ready = 1'b0;
      req_scan_byte  = '0;
      src_idle_pct   = 0;
      sink_idle_pct  = 0;
      load_phase     = 0;
      held_byte      = 8'h1E;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_word(1'b0, 8'hFF);
      send_word(1'b1, 8'h1E);
      send_word(1'b1, 8'h1E);
      send_word(1'b1, 8'h1E);
      send_word(1'b1, 8'h01);
      send_word(1'b1, 8'h5F);
      send_word(1'b1, 8'h60);
      send_word(1'b1, 8'h00);
      send_word(1'b1, 8'hFF);
      send_word(1'b1, 8'h80);
      send_word(1'b1, 8'h39);
      send_word(1'b1, 8'h4E);
      send_word(1'b1, 8'h4A);
      send_word(1'b1, 8'h5A);
      send_word(1'b1, 8'h5A);
      send_word(1'b1, 8'h1E);
      send_word(1'b0, 8'h1E);
      send_word(1'b1, 8'h7F);
      send_word(1'b1, 8'h61);
      send_word(1'b1, 8'h2B);
      send_word(1'b1, 8'h1C);
      send_word(1'b1, 8'h1C);

      for (int p = 0; p < 3; p++) begin
         load_phase = p;
         case (p)
            0: begin
               src_idle_pct  = 33;
               sink_idle_pct = 64;
            end
            1: begin
               src_idle_pct  = 64;
               sink_idle_pct = 33;
            end
            default: begin
               src_idle_pct  = 0;
               sink_idle_pct = 0;
            end
         endcase
         repeat (PHASE_WORDS) send_random_word();
      end
      req_valid <= 1'b0;

      while (expected_pending != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && expected_pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
